@@ hdl/dqs_pkg.sv @@
// Shared types and constants for the double-ended queue with search.
// Used by every module of the block; depends on nothing else.
package dqs_pkg;

  localparam int DEPTH      = 256;
  localparam int ELEM_WIDTH = 32;
  localparam int MAX_BURST  = 16;

  // Cell index width, element count width and a width for burst limits.
  localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > 8) ? CW : 8;

  typedef logic [ELEM_WIDTH-1:0] elem_t;

  typedef enum logic [2:0] {
    OP_PUSH    = 3'd0,
    OP_POP     = 3'd1,
    OP_SHIFT   = 3'd2,
    OP_UNSHIFT = 3'd3,
    OP_READ    = 3'd4,
    OP_SEARCH  = 3'd5,
    OP_CLEAR   = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_NEXT,
    CMD_PREV,
    CMD_LOAD
  } cell_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHIFT,
    S_SWEEP
  } state_t;

  // Control from the sequencer to the row of cells.
  typedef struct packed {
    logic          rot_l;
    logic          rot_r;
    logic          wr;
    logic [CW-1:0] wr_pos;
    elem_t         wdata;
  } chain_ctrl_t;

endpackage

@@ hdl/dqs_cell.sv @@
// One storage cell of the element ring.
// Holds one element and loads from a neighbor or the write bus; uses dqs_pkg.
module dqs_cell (
  input  logic                clk,
  input  dqs_pkg::cell_cmd_t  cmd,
  input  dqs_pkg::elem_t      from_next,
  input  dqs_pkg::elem_t      from_prev,
  input  dqs_pkg::elem_t      wdata,
  output dqs_pkg::elem_t      q
);
  import dqs_pkg::*;

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_NEXT: q <= from_next;
      CMD_PREV: q <= from_prev;
      CMD_LOAD: q <= wdata;
      default:  q <= q;
    endcase
  end

endmodule

@@ hdl/dqs_chain.sv @@
// Row of DEPTH cells closed into a ring; cell 0 holds list position 0.
// Instantiates dqs_cell; uses dqs_pkg.
module dqs_chain (
  input  logic                 clk,
  input  dqs_pkg::chain_ctrl_t ctrl,
  output dqs_pkg::elem_t       head
);
  import dqs_pkg::*;

  elem_t q [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_cmd_t cmd;
    elem_t     prev_word;

    // Unshift moves every cell one place back and feeds the new word to cell 0.
    if (i == 0) begin : g_first
      assign prev_word = ctrl.wdata;
    end else begin : g_rest
      assign prev_word = q[i-1];
    end

    always_comb begin
      if (ctrl.rot_l) begin
        cmd = CMD_NEXT;
      end else if (ctrl.rot_r) begin
        cmd = CMD_PREV;
      end else if (ctrl.wr && ctrl.wr_pos == CW'(i)) begin
        cmd = CMD_LOAD;
      end else begin
        cmd = CMD_HOLD;
      end
    end

    dqs_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .from_next (q[(i + 1) % DEPTH]),
      .from_prev (prev_word),
      .wdata     (ctrl.wdata),
      .q         (q[i])
    );
  end

  assign head = q[0];

endmodule

@@ hdl/dqs_ctrl.sv @@
// Sequencer: decodes each input word, drives the cell ring and the output register.
// Uses dqs_pkg; reads only the head cell of the ring.
module dqs_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            op,
  input  logic [31:0]           value,
  input  logic [7:0]            index,
  input  logic [4:0]            count,
  input  dqs_pkg::elem_t        head,
  output dqs_pkg::chain_ctrl_t  ctrl,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [31:0]           value_out,
  output logic signed [8:0]     position,
  output logic                  ok,
  output logic                  last,
  output logic [8:0]            fill
);
  import dqs_pkg::*;

  state_t          state, state_next;
  logic [CW-1:0]   elems, elems_next;
  logic [CW-1:0]   remaining, remaining_next;
  logic [AW-1:0]   step, step_next;
  logic [CW-1:0]   win_lo, win_lo_next;
  logic [CW-1:0]   win_hi, win_hi_next;
  logic            is_search, is_search_next;
  elem_t           key, key_next;
  logic            found, found_next;
  logic [AW-1:0]   found_pos, found_pos_next;

  logic            out_valid_next;
  logic [31:0]     value_out_next;
  logic signed [8:0] position_next;
  logic            ok_next, last_next;
  logic [8:0]      fill_next;

  logic            out_free, accept;
  op_t             op_code;
  logic [LW-1:0]   elems_w, index_w, count_w, avail_rd;
  logic [CW-1:0]   n_take, n_rd;
  logic            in_win, hit, final_step, emit, adv;

  function automatic logic [LW-1:0] min_lw(input logic [LW-1:0] a, input logic [LW-1:0] b);
    min_lw = (a < b) ? a : b;
  endfunction

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign op_code  = op_t'(op);

  // Burst sizes, cut to what is held and to the burst limit.
  assign elems_w  = LW'(elems);
  assign index_w  = LW'(index);
  assign count_w  = LW'(count);
  assign avail_rd = (index_w < elems_w) ? (elems_w - index_w) : '0;
  assign n_take   = CW'(min_lw(min_lw(count_w, elems_w), LW'(MAX_BURST)));
  assign n_rd     = CW'(min_lw(min_lw(count_w, avail_rd), LW'(MAX_BURST)));

  // During a sweep the head cell holds list position step.
  assign in_win     = !is_search && (CW'(step) >= win_lo) && (CW'(step) < win_hi);
  assign hit        = is_search && (CW'(step) < elems) && (head == key);
  assign final_step = (step == AW'(DEPTH - 1));
  assign emit       = in_win || (is_search && final_step);
  assign adv        = !emit || out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if ((op_code == OP_SHIFT) && (n_take != '0)) begin
            state_next = S_SHIFT;
          end else if (((op_code == OP_POP) && (n_take != '0)) ||
                       ((op_code == OP_READ) && (n_rd != '0)) ||
                       (op_code == OP_SEARCH)) begin
            state_next = S_SWEEP;
          end
        end
      end
      S_SHIFT: begin
        if (out_free && (remaining == CW'(1))) begin
          state_next = S_IDLE;
        end
      end
      S_SWEEP: begin
        if (adv && final_step) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    elems_next     = elems;
    remaining_next = remaining;
    step_next      = step;
    win_lo_next    = win_lo;
    win_hi_next    = win_hi;
    is_search_next = is_search;
    key_next       = key;
    found_next     = found;
    found_pos_next = found_pos;

    out_valid_next = out_valid && !out_ready;
    value_out_next = value_out;
    position_next  = position;
    ok_next        = ok;
    last_next      = last;
    fill_next      = fill;

    ctrl.rot_l  = 1'b0;
    ctrl.rot_r  = 1'b0;
    ctrl.wr     = 1'b0;
    ctrl.wr_pos = elems;
    ctrl.wdata  = ELEM_WIDTH'(value);

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          // Default: one result that carries no element.
          out_valid_next = 1'b1;
          value_out_next = '0;
          position_next  = '0;
          ok_next        = 1'b0;
          last_next      = 1'b1;
          fill_next      = 9'(elems);
          step_next      = '0;
          found_next     = 1'b0;
          key_next       = ELEM_WIDTH'(value);
          case (op_code)
            OP_PUSH: begin
              if (elems != CW'(DEPTH)) begin
                ctrl.wr    = 1'b1;
                elems_next = elems + CW'(1);
                ok_next    = 1'b1;
                fill_next  = 9'(elems + CW'(1));
              end
            end
            OP_UNSHIFT: begin
              if (elems != CW'(DEPTH)) begin
                ctrl.rot_r = 1'b1;
                elems_next = elems + CW'(1);
                ok_next    = 1'b1;
                fill_next  = 9'(elems + CW'(1));
              end
            end
            OP_CLEAR: begin
              elems_next = '0;
              fill_next  = '0;
            end
            OP_SHIFT: begin
              if (n_take != '0) begin
                out_valid_next = 1'b0;
                remaining_next = n_take;
                elems_next     = elems - n_take;
              end
            end
            OP_POP: begin
              if (n_take != '0) begin
                out_valid_next = 1'b0;
                is_search_next = 1'b0;
                win_lo_next    = elems - n_take;
                win_hi_next    = elems;
                elems_next     = elems - n_take;
              end
            end
            OP_READ: begin
              if (n_rd != '0) begin
                out_valid_next = 1'b0;
                is_search_next = 1'b0;
                win_lo_next    = CW'(index);
                win_hi_next    = CW'(index) + n_rd;
              end
            end
            OP_SEARCH: begin
              out_valid_next = 1'b0;
              is_search_next = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_SHIFT: begin
        if (out_free) begin
          ctrl.rot_l     = 1'b1;
          remaining_next = remaining - CW'(1);
          out_valid_next = 1'b1;
          value_out_next = 32'(head);
          position_next  = '0;
          ok_next        = 1'b1;
          last_next      = (remaining == CW'(1));
          fill_next      = 9'(elems);
        end
      end
      S_SWEEP: begin
        if (adv) begin
          ctrl.rot_l = 1'b1;
          step_next  = final_step ? '0 : step + AW'(1);
          if (hit && !found) begin
            found_next     = 1'b1;
            found_pos_next = step;
          end
          if (emit) begin
            out_valid_next = 1'b1;
            fill_next      = 9'(elems);
            if (is_search) begin
              value_out_next = '0;
              ok_next        = found || hit;
              last_next      = 1'b1;
              if (found) begin
                position_next = 9'(found_pos);
              end else if (hit) begin
                position_next = 9'(step);
              end else begin
                position_next = -9'sd1;
              end
            end else begin
              value_out_next = 32'(head);
              position_next  = '0;
              ok_next        = 1'b1;
              last_next      = (CW'(step) == win_hi - CW'(1));
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      elems     <= '0;
      out_valid <= 1'b0;
      found     <= 1'b0;
      step      <= '0;
    end else begin
      state     <= state_next;
      elems     <= elems_next;
      out_valid <= out_valid_next;
      found     <= found_next;
      step      <= step_next;
    end
    remaining <= remaining_next;
    win_lo    <= win_lo_next;
    win_hi    <= win_hi_next;
    is_search <= is_search_next;
    key       <= key_next;
    found_pos <= found_pos_next;
    value_out <= value_out_next;
    position  <= position_next;
    ok        <= ok_next;
    last      <= last_next;
    fill      <= fill_next;
  end

endmodule

@@ hdl/double_ended_queue_with_search_core.sv @@
// Double-ended queue with indexed read and search, built on a ring of cells.
// Input words (op, value, index, count) and result words each move on a
// valid/ready channel; a word is taken when valid and ready are both high.
// Every input word gives one or more result words; the final one has last=1,
// and fill on each of them is the element count after the operation.
// Results leave through an output register, in the cycle after they are formed.
// Push, unshift, clear, unused codes and bursts that move nothing finish in
// their accepting cycle. Shift of n elements takes the accepting cycle, then
// one ring step toward the front per element. Pop, read and search take the
// accepting cycle, then the ring rotates one cell per cycle, unless held by a
// stalled result, past the head cell, where each position is read or compared
// in turn, and a full turn brings it back to its rest alignment.
// A new input word is taken only once the previous one has finished.
// When the receiver stalls, the ring halts when the next result is due, until
// the waiting result is taken. Reset empties the queue at once; the cells keep
// no reset value and no clearing pass is needed, since only held elements are
// ever read. Uses dqs_pkg; instantiates dqs_chain and dqs_ctrl.
module double_ended_queue_with_search_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        op,
  input  logic [31:0]       value,
  input  logic [7:0]        index,
  input  logic [4:0]        count,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       value_out,
  output logic signed [8:0] position,
  output logic              ok,
  output logic              last,
  output logic [8:0]        fill
);
  import dqs_pkg::*;

  chain_ctrl_t ctrl;
  elem_t       head;

  dqs_chain u_chain (
    .clk  (clk),
    .ctrl (ctrl),
    .head (head)
  );

  dqs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .value     (value),
    .index     (index),
    .count     (count),
    .head      (head),
    .ctrl      (ctrl),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value_out (value_out),
    .position  (position),
    .ok        (ok),
    .last      (last),
    .fill      (fill)
  );

`ifndef ASSERT_OFF
  // Only a burst has several results, and each of them carries an element.
  a_burst_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> ok)
    else $error("non-final result without an element");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> fill <= 9'(DEPTH))
    else $error("fill exceeds the store depth");

  a_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid && position == -9'sd1 |-> !ok && last)
    else $error("search miss reported with ok set or not final");

  // No new word is taken while a result is still stalled at the output.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while a result is stalled");
`endif

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for double_ended_queue_with_search_core.
// Holds a software mirror of the deque built on dqs_pkg types and compares every result word.
module tb;
  import dqs_pkg::*;

  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int WATCHDOG_CYCLES = 4000;

  typedef struct {
    logic [31:0] value_out;
    logic [8:0]  position;
    logic        ok;
    logic        last;
    logic [8:0]  fill;
  } result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [2:0]        op = OP_CLEAR;
  logic [31:0]       value = '0;
  logic [7:0]        index = '0;
  logic [4:0]        count = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [31:0]       value_out;
  logic signed [8:0] position;
  logic              ok;
  logic              last;
  logic [8:0]        fill;

  // Mirror of the queue contents and the expected result words in order.
  logic [31:0] mirror_cells [DEPTH];
  int          mirror_front = 0;
  int          mirror_fill = 0;
  result_t     pending_results [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_count = 0;
  int quiet_cycles = 0;

  logic [31:0] value_pool [8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001,
                                  32'h5555_AAAA, 32'h1234_5678, 32'hDEAD_BEEF, 32'h0000_00FF};

  double_ended_queue_with_search_core u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .op       (op),
    .value    (value),
    .index    (index),
    .count    (count),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .value_out(value_out),
    .position (position),
    .ok       (ok),
    .last     (last),
    .fill     (fill)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int slot_at(int pos);
    return (mirror_front + pos) % DEPTH;
  endfunction

  function automatic int burst_len(int want, int avail);
    int n;
    n = (want < avail) ? want : avail;
    return (n < MAX_BURST) ? n : MAX_BURST;
  endfunction

  // Applies one word to the mirror and queues the result words it must produce.
  task automatic predict_deque_results(logic [2:0] code, logic [31:0] val, logic [7:0] idx,
                                       logic [4:0] cnt);
    result_t     res;
    logic [31:0] moved [$];
    int          n;
    int          hit;
    n = 0;
    hit = -1;
    res = '{value_out: '0, position: '0, ok: 1'b0, last: 1'b0, fill: '0};
    case (code)
      OP_PUSH, OP_UNSHIFT: begin
        if (mirror_fill < DEPTH) begin
          if (code == OP_PUSH) begin
            mirror_cells[slot_at(mirror_fill)] = val;
          end else begin
            mirror_front = slot_at(DEPTH - 1);
            mirror_cells[mirror_front] = val;
          end
          mirror_fill++;
          res.ok = 1'b1;
        end
      end
      OP_POP: begin
        n = burst_len(cnt, mirror_fill);
        for (int i = 0; i < n; i++) moved.push_back(mirror_cells[slot_at(mirror_fill - n + i)]);
        mirror_fill -= n;
      end
      OP_SHIFT: begin
        n = burst_len(cnt, mirror_fill);
        for (int i = 0; i < n; i++) moved.push_back(mirror_cells[slot_at(i)]);
        mirror_front = slot_at(n);
        mirror_fill -= n;
      end
      OP_READ: begin
        if (idx < mirror_fill) n = burst_len(cnt, mirror_fill - idx);
        for (int i = 0; i < n; i++) moved.push_back(mirror_cells[slot_at(idx + i)]);
      end
      OP_SEARCH: begin
        for (int i = 0; i < mirror_fill; i++) begin
          if (hit < 0 && mirror_cells[slot_at(i)] == val) hit = i;
        end
        res.position = hit[8:0];
        res.ok = (hit >= 0);
      end
      OP_CLEAR: begin
        mirror_front = 0;
        mirror_fill = 0;
      end
      default: ;
    endcase
    res.fill = mirror_fill[8:0];
    if (moved.size() == 0) begin
      res.last = 1'b1;
      pending_results.push_back(res);
    end else begin
      foreach (moved[i]) begin
        res.value_out = moved[i];
        res.ok = 1'b1;
        res.last = (i == moved.size() - 1);
        pending_results.push_back(res);
      end
    end
  endtask

  // Offers one input word and returns at the edge where it is taken.
  task automatic send_word(logic [2:0] code, logic [31:0] val, logic [7:0] idx, logic [4:0] cnt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= code;
    value <= val;
    index <= idx;
    count <= cnt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_deque_results(code, val, idx, cnt);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Result checking and the watchdog on lack of progress.
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: value_out 0x%0h", value_out);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("value_out", want.value_out, value_out);
        check_field("position", 32'(want.position), 32'($unsigned(position)));
        check_field("ok", 32'(want.ok), 32'(ok));
        check_field("last", 32'(want.last), 32'(last));
        check_field("fill", 32'(want.fill), 32'(fill));
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic test_edge_cases();
    send_word(OP_POP, 32'h0, 8'd0, 5'd5);
    send_word(OP_SHIFT, 32'h0, 8'd0, 5'd0);
    send_word(OP_READ, 32'h0, 8'd0, 5'd1);
    send_word(OP_SEARCH, 32'h0, 8'd0, 5'd0);
    send_word(OP_PUSH, 32'h0000_0000, 8'd0, 5'd0);
    send_word(OP_PUSH, 32'hFFFF_FFFF, 8'hFF, 5'h1F);
    send_word(OP_UNSHIFT, 32'h5555_AAAA, 8'd0, 5'd0);
    send_word(OP_UNSHIFT, 32'h0000_0001, 8'd0, 5'd0);
    send_word(OP_READ, 32'h0, 8'd0, 5'd31);
    send_word(OP_READ, 32'h0, 8'd3, 5'd1);
    send_word(OP_READ, 32'h0, 8'd4, 5'd2);
    send_word(OP_READ, 32'h0, 8'd255, 5'd16);
    send_word(OP_SEARCH, 32'hFFFF_FFFF, 8'd0, 5'd0);
    send_word(OP_SEARCH, 32'h1234_5678, 8'd0, 5'd0);
    send_word(OP_POP, 32'h0, 8'd0, 5'd0);
    send_word(OP_POP, 32'h0, 8'd0, 5'd1);
    send_word(OP_SHIFT, 32'h0, 8'd0, 5'd2);
    send_word(OP_UNUSED, 32'hFFFF_FFFF, 8'hFF, 5'h1F);
    send_word(OP_SHIFT, 32'h0, 8'd0, 5'd31);
    send_word(OP_PUSH, 32'hA5A5_5A5A, 8'd0, 5'd0);
    send_word(OP_CLEAR, 32'h0, 8'd0, 5'd0);
  endtask

  // Fills the store to the top, checks refused inserts and bursts at the far end.
  task automatic test_full_store();
    send_word(OP_CLEAR, 32'h0, 8'd0, 5'd0);
    while (mirror_fill < DEPTH) begin
      send_word($urandom_range(1) ? OP_PUSH : OP_UNSHIFT, $urandom, 8'($urandom), 5'($urandom));
    end
    send_word(OP_PUSH, 32'hFFFF_FFFF, 8'd0, 5'd0);
    send_word(OP_UNSHIFT, 32'hFFFF_FFFF, 8'd0, 5'd0);
    send_word(OP_READ, 32'h0, 8'd255, 5'd31);
    send_word(OP_READ, 32'h0, 8'd0, 5'd16);
    send_word(OP_SEARCH, mirror_cells[slot_at(DEPTH - 1)], 8'd0, 5'd0);
    send_word(OP_POP, 32'h0, 8'd0, 5'd31);
    send_word(OP_SHIFT, 32'h0, 8'd0, 5'd16);
    send_word(OP_UNSHIFT, 32'h8000_0000, 8'd0, 5'd0);
    send_word(OP_READ, 32'h0, 8'd0, 5'd3);
    send_word(OP_CLEAR, 32'h0, 8'd0, 5'd0);
  endtask

  task automatic test_random_traffic(int items);
    logic [2:0]  code;
    logic [31:0] val;
    logic [7:0]  idx;
    logic [4:0]  cnt;
    int          roll;
    for (int k = 0; k < items; k++) begin
      roll = $urandom_range(99);
      if (roll < 28) code = OP_PUSH;
      else if (roll < 46) code = OP_UNSHIFT;
      else if (roll < 58) code = OP_POP;
      else if (roll < 70) code = OP_SHIFT;
      else if (roll < 82) code = OP_READ;
      else if (roll < 94) code = OP_SEARCH;
      else if (roll < 97) code = OP_CLEAR;
      else code = OP_UNUSED;
      val = $urandom_range(1) ? value_pool[$urandom_range(7)] : $urandom;
      // Searches mostly look for something that is held, to hit first-match cases.
      if (code == OP_SEARCH && mirror_fill > 0 && $urandom_range(9) < 6) begin
        val = mirror_cells[slot_at($urandom_range(mirror_fill - 1))];
      end
      if ($urandom_range(3) == 0) idx = 8'($urandom_range(255));
      else idx = 8'($urandom_range((mirror_fill + 1 < 255) ? mirror_fill + 1 : 255));
      cnt = ($urandom_range(4) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(17));
      send_word(code, val, idx, cnt);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 13;
    recv_idle_pct = 64;
    test_edge_cases();
    test_full_store();
    test_random_traffic(75);
    send_idle_pct = 64;
    recv_idle_pct = 13;
    test_random_traffic(75);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(75);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // Pop, read and search keep the ring turning for a full revolution.
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
